[src/rbd_pkg.sv]
package rbd_pkg;

    localparam int MAX_WIDTH_DEF   = 32;
    localparam int LABEL_BITS_DEF  = 8;
    localparam int ROW_BITS        = 10;
    localparam int MAX_HEIGHT      = 1024;
    localparam int RST_HEIGHT      = 32;
    localparam int WIDTH_CFG_BITS  = 6;
    localparam int HEIGHT_CFG_BITS = 11;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [7:0] ALPHA_BORDER = 8'd255;
    localparam logic [7:0] ALPHA_INNER  = 8'd63;

    typedef struct packed {
        logic [7:0] region_label;
        logic       labelled;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_label;
        logic       drawn;
        logic       is_border;
        logic [7:0] alpha;
        logic       frame_last;
    } t_out_item;

    typedef enum logic [1:0] {
        EV_PIXEL,
        EV_COLUMN,
        EV_EDGE
    } t_ev_kind;

    typedef struct packed {
        logic     valid;
        t_ev_kind kind;
        logic     judge;
        logic     top_ok;
        logic     bot_ok;
        logic     flush_last;
        logic     hold;
        logic     pend_out;
    } t_ev;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_EDGE,
        ST_EDGE_LAST,
        ST_FLUSH,
        ST_FLUSH_EDGE
    } t_state;

endpackage

[src/region_border_detect_top.sv]
// A result leaves the output register once the transaction that completes its 3x3 window has
// passed the input register and then the result register; a stalled output holds both.
// Pixels are accepted one per cycle within a row while the output is not stalled; each row after
// the first adds a right-edge column step, and the last pixel of a frame is followed by a flush.
// Reset: synchronous, active low; clears control and window state, line stores keep contents.
module region_border_detect_top #(
    parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = rbd_pkg::LABEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rbd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rbd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rbd_pkg::t_out_item                o_out_data
);
    import rbd_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int PIX_BITS = LABEL_BITS + 1;

    t_ev                 w_ev;
    logic [COL_BITS-1:0] w_ev_col;
    logic [PIX_BITS-1:0] w_ev_pix;
    logic                w_adv;

    rbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_adv       (w_adv),
        .o_ev        (w_ev),
        .o_ev_col    (w_ev_col),
        .o_ev_pix    (w_ev_pix)
    );

    rbd_judge #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev        (w_ev),
        .i_ev_col    (w_ev_col),
        .i_ev_pix    (w_ev_pix),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_accept_to_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_ev.valid && (w_ev.kind == EV_PIXEL))
        else $error("accepted transaction did not reach the input register");

    a_edge_judges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev.valid && (w_ev.kind == EV_EDGE) |-> w_ev.judge)
        else $error("right-edge column without a judged pixel");

    a_hold_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev.valid && w_ev.hold |-> w_ev.flush_last && !w_ev.pend_out)
        else $error("held result is not the final pixel of the frame");

    a_alpha_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drawn |->
            ((o_out_data.alpha == ALPHA_BORDER) == o_out_data.is_border))
        else $error("alpha does not match border flag");

endmodule

[src/rbd_ctrl.sv]
module rbd_ctrl #(
    parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = rbd_pkg::LABEL_BITS_DEF,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int PIX_BITS  = LABEL_BITS + 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [rbd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rbd_pkg::t_in_item                    i_in_data,
    input  logic                                 i_adv,
    output rbd_pkg::t_ev                         o_ev,
    output logic [COL_BITS-1:0]                  o_ev_col,
    output logic [PIX_BITS-1:0]                  o_ev_pix
);
    import rbd_pkg::*;

    t_state                  r_state, n_state;
    logic [COL_BITS-1:0]     r_col, n_col;
    logic [ROW_BITS-1:0]     r_row, n_row;
    logic [COL_BITS-1:0]     r_wlast, n_wlast;
    logic [ROW_BITS-1:0]     r_hlast, n_hlast;
    logic                    r_edge_top, n_edge_top;
    logic                    r_pend, n_pend;
    t_ev                     r_ev, n_ev;
    logic [COL_BITS-1:0]     r_ev_col, n_ev_col;
    logic [PIX_BITS-1:0]     r_ev_pix, n_ev_pix;

    logic                         accept;
    logic                         col_end;
    logic                         row_end;
    logic [LABEL_BITS+7:0]        lab_ext;
    logic [WIDTH_CFG_BITS-1:0]    wv;
    logic [HEIGHT_CFG_BITS-1:0]   hv;
    logic                         cfg_w;
    logic                         cfg_h;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_adv && (r_state == ST_RUN);
    assign accept      = i_in_valid && o_in_ready;
    assign col_end     = (r_col == r_wlast);
    assign row_end     = (r_row == r_hlast);
    assign lab_ext     = {LABEL_BITS'(0), i_in_data.region_label};
    assign cfg_w       = i_cfg_valid && (i_cfg_index == CFG_FRAME_WIDTH);
    assign cfg_h       = i_cfg_valid && (i_cfg_index == CFG_FRAME_HEIGHT);

    always_comb begin
        wv = i_cfg_data[WIDTH_CFG_BITS-1:0];
        hv = i_cfg_data[HEIGHT_CFG_BITS-1:0];
        if (wv == '0) begin
            n_wlast = '0;
        end else if (wv > WIDTH_CFG_BITS'(MAX_WIDTH)) begin
            n_wlast = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            n_wlast = COL_BITS'(wv - 1'b1);
        end
        if (hv == '0) begin
            n_hlast = '0;
        end else if (hv > HEIGHT_CFG_BITS'(MAX_HEIGHT)) begin
            n_hlast = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            n_hlast = ROW_BITS'(hv - 1'b1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_edge_top = r_edge_top;
        n_pend     = r_pend;
        n_ev       = '0;
        n_ev.kind  = EV_PIXEL;
        n_ev_col   = r_col;
        n_ev_pix   = i_in_data.labelled ? {1'b1, lab_ext[LABEL_BITS-1:0]} : '0;
        case (r_state)
            ST_RUN: begin
                if (accept) begin
                    n_ev.valid    = 1'b1;
                    n_ev.kind     = EV_PIXEL;
                    n_ev.judge    = (r_row != '0) && (r_col != '0);
                    n_ev.top_ok   = (r_row > ROW_BITS'(1));
                    n_ev.bot_ok   = 1'b1;
                    n_ev.pend_out = r_pend;
                    n_pend        = 1'b0;
                    n_edge_top    = (r_row > ROW_BITS'(1));
                    if (col_end) begin
                        n_col = '0;
                        n_row = row_end ? '0 : r_row + 1'b1;
                        if (r_row != '0) begin
                            n_state = row_end ? ST_EDGE_LAST : ST_EDGE;
                        end else begin
                            n_state = row_end ? ST_FLUSH : ST_RUN;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            ST_EDGE, ST_EDGE_LAST: begin
                n_ev.valid  = 1'b1;
                n_ev.kind   = EV_EDGE;
                n_ev.judge  = 1'b1;
                n_ev.top_ok = r_edge_top;
                n_ev.bot_ok = 1'b1;
                n_ev_col    = '0;
                n_state     = (r_state == ST_EDGE_LAST) ? ST_FLUSH : ST_RUN;
            end
            ST_FLUSH: begin
                n_ev.valid  = 1'b1;
                n_ev.kind   = EV_COLUMN;
                n_ev.judge  = (r_col != '0);
                n_ev.top_ok = (r_hlast != '0);
                if (col_end) begin
                    n_col   = '0;
                    n_state = ST_FLUSH_EDGE;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_FLUSH_EDGE: begin
                n_ev.valid      = 1'b1;
                n_ev.kind       = EV_EDGE;
                n_ev.judge      = 1'b1;
                n_ev.top_ok     = (r_hlast != '0);
                n_ev.flush_last = 1'b1;
                // full-width frame taller than one row: final pixel waits for the next transaction
                n_ev.hold       = (r_wlast == COL_BITS'(MAX_WIDTH - 1)) && (r_hlast != '0);
                n_pend          = n_ev.hold;
                n_ev_col        = '0;
                n_state         = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_col      <= '0;
            r_row      <= '0;
            r_wlast    <= COL_BITS'(MAX_WIDTH - 1);
            r_hlast    <= ROW_BITS'(RST_HEIGHT - 1);
            r_edge_top <= 1'b0;
            r_pend     <= 1'b0;
            r_ev       <= '0;
        end else begin
            if (i_adv) begin
                r_state    <= n_state;
                r_col      <= n_col;
                r_row      <= n_row;
                r_edge_top <= n_edge_top;
                r_pend     <= n_pend;
                r_ev       <= n_ev;
            end
            if (cfg_w || cfg_h) begin
                r_state <= ST_RUN;
                r_col   <= '0;
                r_row   <= '0;
                r_pend  <= 1'b0;
            end
            if (cfg_w) begin
                r_wlast <= n_wlast;
            end
            if (cfg_h) begin
                r_hlast <= n_hlast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ev_col <= n_ev_col;
            r_ev_pix <= n_ev_pix;
        end
    end

    assign o_ev     = r_ev;
    assign o_ev_col = r_ev_col;
    assign o_ev_pix = r_ev_pix;

endmodule

[src/rbd_judge.sv]
module rbd_judge #(
    parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = rbd_pkg::LABEL_BITS_DEF,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int PIX_BITS  = LABEL_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rbd_pkg::t_ev          i_ev,
    input  logic [COL_BITS-1:0]   i_ev_col,
    input  logic [PIX_BITS-1:0]   i_ev_pix,
    output logic                  o_adv,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rbd_pkg::t_out_item    o_out_data
);
    import rbd_pkg::*;

    logic [PIX_BITS-1:0] r_line_a [MAX_WIDTH];
    logic [PIX_BITS-1:0] r_line_b [MAX_WIDTH];

    logic [PIX_BITS-1:0] r_l_top, r_l_mid, r_l_bot;
    logic [PIX_BITS-1:0] r_c_top, r_c_mid, r_c_bot;
    logic                r_l_ok, r_c_ok;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           r_pend;

    logic [PIX_BITS-1:0]   n_top, n_mid, n_bot;
    logic                  n_ok;
    logic                  mism;
    logic                  drawn;
    logic                  border;
    logic [LABEL_BITS+7:0] lab_ext;
    t_out_item             judged;
    logic                  emit;

    assign o_adv = !r_out_valid || i_out_ready;
    assign n_top = r_line_b[i_ev_col];
    assign n_mid = r_line_a[i_ev_col];
    assign n_bot = i_ev_pix;
    assign n_ok  = (i_ev.kind != EV_EDGE);

    always_comb begin
        mism = 1'b0;
        if (i_ev.top_ok && (r_c_top != r_c_mid)) mism = 1'b1;
        if (i_ev.bot_ok && (r_c_bot != r_c_mid)) mism = 1'b1;
        if (r_l_ok) begin
            if (r_l_mid != r_c_mid) mism = 1'b1;
            if (i_ev.top_ok && (r_l_top != r_c_mid)) mism = 1'b1;
            if (i_ev.bot_ok && (r_l_bot != r_c_mid)) mism = 1'b1;
        end
        if (n_ok) begin
            if (n_mid != r_c_mid) mism = 1'b1;
            if (i_ev.top_ok && (n_top != r_c_mid)) mism = 1'b1;
            if (i_ev.bot_ok && (n_bot != r_c_mid)) mism = 1'b1;
        end
    end

    always_comb begin
        drawn             = r_c_mid[LABEL_BITS];
        border            = drawn && mism;
        lab_ext           = {8'd0, r_c_mid[LABEL_BITS-1:0]};
        judged.out_label  = drawn ? lab_ext[7:0] : 8'd0;
        judged.drawn      = drawn;
        judged.is_border  = border;
        judged.alpha      = drawn ? (border ? ALPHA_BORDER : ALPHA_INNER) : 8'd0;
        judged.frame_last = i_ev.flush_last;
    end

    assign emit = i_ev.valid && ((i_ev.judge && !i_ev.hold) || i_ev.pend_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_l_ok      <= 1'b0;
            r_c_ok      <= 1'b0;
            r_l_top     <= '0;
            r_l_mid     <= '0;
            r_l_bot     <= '0;
            r_c_top     <= '0;
            r_c_mid     <= '0;
            r_c_bot     <= '0;
        end else if (o_adv) begin
            r_out_valid <= emit;
            if (i_ev.valid) begin
                r_l_top <= r_c_top;
                r_l_mid <= r_c_mid;
                r_l_bot <= r_c_bot;
                r_c_top <= n_top;
                r_c_mid <= n_mid;
                r_c_bot <= n_bot;
                r_l_ok  <= (n_ok && (i_ev_col == '0)) ? 1'b0 : r_c_ok;
                r_c_ok  <= n_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out <= i_ev.pend_out ? r_pend : judged;
            if (i_ev.valid && i_ev.hold) begin
                r_pend <= judged;
            end
            if (i_ev.valid && (i_ev.kind == EV_PIXEL)) begin
                r_line_b[i_ev_col] <= r_line_a[i_ev_col];
                r_line_a[i_ev_col] <= i_ev_pix;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[tb/region_border_detect_checker.sv]
module region_border_detect_checker
    import rbd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_in_item                 i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_out_item                i_out_data,
    output int                       o_fail_count,
    output int                       o_pending_count,
    output int                       o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_CAP    = MAX_WIDTH_DEF + 1;
    localparam int PRINT_LIMIT = 30;

    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned col_idx;
    int unsigned row_idx;
    logic [LABEL_BITS_DEF:0] line_rows [3][MAX_WIDTH_DEF];
    t_out_item deferred_pixel;
    logic      deferred_valid;
    t_out_item expected_pixels [$];

    task automatic report_mismatch(string msg);
        if (o_fail_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_out_item classify(int r, int c);
        t_out_item res;
        logic [LABEL_BITS_DEF:0] self;
        int nr;
        int nc;
        res = '0;
        self = line_rows[r % 3][c];
        res.frame_last = (r == int'(frame_h) - 1) && (c == int'(frame_w) - 1);
        if (!self[LABEL_BITS_DEF])
            return res;
        res.drawn = 1'b1;
        res.out_label = self[LABEL_BITS_DEF-1:0];
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = r + dr;
                nc = c + dc;
                if ((dr == 0 && dc == 0) || nr < 0 || nc < 0) continue;
                if (nr >= int'(frame_h) || nc >= int'(frame_w)) continue;
                if (line_rows[nr % 3][nc] != self)
                    res.is_border = 1'b1;
            end
        end
        res.alpha = res.is_border ? ALPHA_BORDER : ALPHA_INNER;
        return res;
    endfunction

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        int unsigned v;
        case (idx)
            CFG_FRAME_WIDTH: begin
                v = data[WIDTH_CFG_BITS-1:0];
                if (v == 0) v = 1;
                if (v > MAX_WIDTH_DEF) v = MAX_WIDTH_DEF;
                frame_w = v;
            end
            CFG_FRAME_HEIGHT: begin
                v = data;
                if (v == 0) v = 1;
                if (v > MAX_HEIGHT) v = MAX_HEIGHT;
                frame_h = v;
            end
            default: return;
        endcase
        // a width or height write restarts the frame and drops a held pixel
        col_idx = 0;
        row_idx = 0;
        deferred_valid = 1'b0;
    endtask

    task automatic accept_pixel(t_in_item px);
        t_out_item batch [$];
        int r;
        int c;
        int w;
        r = row_idx;
        c = col_idx;
        w = frame_w;
        if (deferred_valid) begin
            batch.push_back(deferred_pixel);
            deferred_valid = 1'b0;
        end
        line_rows[r % 3][c] = px.labelled ? {1'b1, px.region_label} : '0;
        if (r >= 1 && c >= 1)
            batch.push_back(classify(r - 1, c - 1));
        if (r >= 1 && c == w - 1)
            batch.push_back(classify(r - 1, w - 1));
        if (r == int'(frame_h) - 1 && c == w - 1)
            for (int i = 0; i < w; i++)
                batch.push_back(classify(r, i));
        if (batch.size() > STEP_CAP) begin
            deferred_pixel = batch[STEP_CAP];
            deferred_valid = 1'b1;
        end
        for (int k = 0; k < batch.size() && k < STEP_CAP; k++)
            expected_pixels.push_back(batch[k]);
        col_idx++;
        if (col_idx >= frame_w) begin
            col_idx = 0;
            row_idx++;
            if (row_idx >= frame_h) row_idx = 0;
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        int n;
        n = o_result_count;
        o_result_count++;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected (label %0d)",
                                      n, got.out_label));
            return;
        end
        want = expected_pixels.pop_front();
        if (got.out_label !== want.out_label)
            report_mismatch($sformatf("result %0d out_label %0d, want %0d",
                                      n, got.out_label, want.out_label));
        if (got.drawn !== want.drawn)
            report_mismatch($sformatf("result %0d drawn %0b, want %0b", n, got.drawn, want.drawn));
        if (got.is_border !== want.is_border)
            report_mismatch($sformatf("result %0d is_border %0b, want %0b",
                                      n, got.is_border, want.is_border));
        if (got.alpha !== want.alpha)
            report_mismatch($sformatf("result %0d alpha %0d, want %0d", n, got.alpha, want.alpha));
        if (got.frame_last !== want.frame_last)
            report_mismatch($sformatf("result %0d frame_last %0b, want %0b",
                                      n, got.frame_last, want.frame_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_w = MAX_WIDTH_DEF;
            frame_h = RST_HEIGHT;
            col_idx = 0;
            row_idx = 0;
            deferred_valid = 1'b0;
            expected_pixels.delete();
            o_fail_count = 0;
            o_result_count = 0;
            o_pending_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) accept_pixel(i_in_data);
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            o_pending_count = expected_pixels.size();
        end
    end

endmodule

[tb/region_border_detect_top_test.sv]
module region_border_detect_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rbd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 380;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    t_in_item                 in_data   = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_ready;
    logic                     in_ready;
    logic                     out_valid;
    t_out_item                out_data;

    int fail_count;
    int pending_count;
    int result_count;
    int items_sent    = 0;
    int reg_writes    = 0;
    int settings_used = 0;
    int hold_requests = 0;
    int sender_burst  = 0;

    logic [7:0] prev_label = '0;
    logic [7:0] palette [3];
    int stay_pct = 80;
    int hole_pct = 10;

    region_border_detect_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    region_border_detect_checker border_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_result_count  (result_count)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic t_in_item make_pixel(logic [7:0] label, logic labelled);
        t_in_item px;
        px.region_label = label;
        px.labelled = labelled;
        return px;
    endfunction

    function automatic t_in_item next_pixel();
        t_in_item px;
        if ($urandom_range(0, 99) >= stay_pct)
            prev_label = ($urandom_range(0, 15) == 0) ? 8'($urandom) : palette[$urandom_range(0, 2)];
        px.region_label = prev_label;
        px.labelled = ($urandom_range(0, 99) >= hole_pct);
        if (!px.labelled && $urandom_range(0, 1) == 1)
            px.region_label = 8'($urandom);
        return px;
    endfunction

    task automatic send_item(t_in_item px);
        int gap;
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= px;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_pixels(int n);
        foreach (palette[i]) palette[i] = 8'($urandom);
        stay_pct = $urandom_range(40, 97);
        hole_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        repeat (n) send_item(next_pixel());
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(data);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // all expected results in, then a settling wait for work that yields none
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(int w_data, int h_data);
        wait_idle();
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_FRAME_WIDTH, w_data);
            write_reg(CFG_FRAME_HEIGHT, h_data);
        end else begin
            write_reg(CFG_FRAME_HEIGHT, h_data);
            write_reg(CFG_FRAME_WIDTH, w_data);
        end
        settings_used++;
    endtask

    initial begin : result_sink
        int gap;
        int burst;
        int holds_served;
        burst = 0;
        holds_served = 0;
        forever begin
            if (hold_requests > holds_served) begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = draw_gap(burst);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int w;
        int h;
        int n;
        int w_data;
        int h_data;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unused indexes must not disturb anything
        write_reg(CFG_SPARE_A, 'h7FF);
        write_reg(CFG_SPARE_B, 'h155);

        // uniform 3x3: every pixel inner
        set_frame(3, 3);
        repeat (9) send_item(make_pixel(8'h00, 1'b1));
        // holes, label bits on holes, one odd label
        send_item(make_pixel(8'hFF, 1'b1));
        send_item(make_pixel(8'hFF, 1'b1));
        send_item(make_pixel(8'hFF, 1'b0));
        send_item(make_pixel(8'hFF, 1'b1));
        send_item(make_pixel(8'hFF, 1'b1));
        send_item(make_pixel(8'h80, 1'b1));
        send_item(make_pixel(8'h00, 1'b0));
        send_item(make_pixel(8'hFF, 1'b1));
        send_item(make_pixel(8'hFF, 1'b1));

        // zero width and height act as one: single-pixel frames
        set_frame(0, 0);
        send_item(make_pixel(8'h55, 1'b1));
        send_item(make_pixel(8'hAA, 1'b0));

        // high width bits are dropped
        set_frame(2 + 64 * 31, 2);
        repeat (4) send_item(make_pixel(8'h01, 1'b1));

        // full width, oversized value; the final pixel is held over a step,
        // the second frame's held pixel is dropped by the next write
        hold_requests++;
        set_frame(63, 2);
        send_pixels(2 * MAX_WIDTH_DEF * 2);

        set_frame(1, MAX_HEIGHT + $urandom_range(1, 1023));
        send_pixels(40);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       begin w = 1;                       h = $urandom_range(1, 4); end
                1:       begin w = $urandom_range(2, 4);    h = 1; end
                5:       begin w = $urandom_range(9, 31);   h = $urandom_range(2, 3); end
                6:       begin w = $urandom_range(1, 6);    h = MAX_HEIGHT; end
                7:       begin w = MAX_WIDTH_DEF;           h = 1; end
                default: begin w = $urandom_range(2, 8);    h = $urandom_range(2, 6); end
            endcase
            if (h == MAX_HEIGHT) begin
                n = w * 3 + $urandom_range(0, 20);
            end else begin
                n = w * h * $urandom_range(1, 2);
                if (n > 120) n = w * h;
                if ($urandom_range(0, 3) == 0) n += $urandom_range(0, w * h - 1);
            end
            w_data = w;
            if (w == MAX_WIDTH_DEF && $urandom_range(0, 1) == 1)
                w_data = $urandom_range(MAX_WIDTH_DEF + 1, 63);
            else if (w == 1 && $urandom_range(0, 1) == 1)
                w_data = 64 * $urandom_range(0, 31);
            else if ($urandom_range(0, 3) == 0)
                w_data = w + 64 * $urandom_range(1, 31);
            h_data = h;
            if (h == MAX_HEIGHT && $urandom_range(0, 1) == 1)
                h_data = $urandom_range(MAX_HEIGHT + 1, 2047);
            else if (h == 1 && $urandom_range(0, 1) == 1)
                h_data = 0;
            set_frame(w_data, h_data);
            send_pixels(n);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d pixels through %0d frame shapes (width 1..32, height 1..1024), %0d reg writes",
                 items_sent, settings_used, reg_writes);
        $display("Checked %0d border/inner/hole results, %0d mismatches, %0d still outstanding",
                 result_count, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
